### hdl/dpy_pkg.sv
// Shared constants, register codes and helpers of the Drucker-Prager yield evaluator.
package dpy_pkg;

  localparam int STRESS_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int N_ELEM           = 9;
  localparam int ALPHA_W          = 17;
  localparam int ALPHA_FRAC       = 16;
  localparam int COH_W            = 31;
  localparam int YIELD_W          = 32;
  localparam int GRAD_W           = 19;
  localparam int CFG_IDX_W        = 4;
  localparam int CFG_DATA_W       = 32;

  localparam longint YIELD_MAX = 64'sd2147483647;
  localparam longint YIELD_MIN = -64'sd2147483648;
  localparam longint GRAD_MAX  = 64'sd262143;
  localparam longint GRAD_MIN  = -64'sd262144;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 4'd0,
    CFG_COH   = 4'd1
  } cfg_idx_t;

  function automatic logic is_diag(input int idx);
    return (idx == 0) || (idx == 4) || (idx == 8);
  endfunction

endpackage

### hdl/drucker_prager_yield_eval.sv
// Top level of the Drucker-Prager yield evaluator: configuration, lanes and output merge.
// One stress point is taken in every clock cycle and busy never rises. Each result appears
// on the out_ ports for one cycle with out_valid high. The depth of the pipeline is set by
// the one-bit-per-stage square-root pipeline and the nine parallel divider lanes, which run
// side by side. The receiver must take every result in the cycle it is shown, since there
// is no way to hold results off.
// Registers are written through the cfg_ port, which is always ready.
module drucker_prager_yield_eval #(
  parameter int STRESS_WIDTH = dpy_pkg::STRESS_WIDTH_DEF,
  parameter int FRAC_BITS    = dpy_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [STRESS_WIDTH-1:0]       in_stress_xx,
  input  logic signed [STRESS_WIDTH-1:0]       in_stress_xy,
  input  logic signed [STRESS_WIDTH-1:0]       in_stress_xz,
  input  logic signed [STRESS_WIDTH-1:0]       in_stress_yx,
  input  logic signed [STRESS_WIDTH-1:0]       in_stress_yy,
  input  logic signed [STRESS_WIDTH-1:0]       in_stress_yz,
  input  logic signed [STRESS_WIDTH-1:0]       in_stress_zx,
  input  logic signed [STRESS_WIDTH-1:0]       in_stress_zy,
  input  logic signed [STRESS_WIDTH-1:0]       in_stress_zz,
  output logic                                 out_valid,
  output logic signed [dpy_pkg::YIELD_W-1:0]   out_yield_value,
  output logic signed [dpy_pkg::GRAD_W-1:0]    out_grad_xx,
  output logic signed [dpy_pkg::GRAD_W-1:0]    out_grad_xy,
  output logic signed [dpy_pkg::GRAD_W-1:0]    out_grad_xz,
  output logic signed [dpy_pkg::GRAD_W-1:0]    out_grad_yx,
  output logic signed [dpy_pkg::GRAD_W-1:0]    out_grad_yy,
  output logic signed [dpy_pkg::GRAD_W-1:0]    out_grad_yz,
  output logic signed [dpy_pkg::GRAD_W-1:0]    out_grad_zx,
  output logic signed [dpy_pkg::GRAD_W-1:0]    out_grad_zy,
  output logic signed [dpy_pkg::GRAD_W-1:0]    out_grad_zz,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dpy_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dpy_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import dpy_pkg::*;

  localparam int W     = STRESS_WIDTH;
  localparam int R_W   = W + 4;
  localparam int G_W   = FRAC_BITS + 2;
  localparam int DEPTH = (R_W > G_W) ? R_W : G_W;
  localparam int X9_W  = 2 * W + 8;
  localparam int SQ_W  = 2 * W + 4;
  localparam int AT_W  = W + 4;
  localparam int SW    = (W + 7 > 34) ? W + 7 : 34;
  localparam int GSW   = FRAC_BITS + 12;
  localparam int SHL   = (FRAC_BITS >= ALPHA_FRAC) ? FRAC_BITS - ALPHA_FRAC : 0;
  localparam int SHR   = (FRAC_BITS < ALPHA_FRAC) ? ALPHA_FRAC - FRAC_BITS : 0;
  localparam int LAT   = DEPTH + 6;
  localparam logic [X9_W-1:0] THR =
    X9_W'((64'd9 << (2 * FRAC_BITS)) / 64'd1000000);
  localparam logic signed [SW-1:0]  YMAX_S = SW'(YIELD_MAX);
  localparam logic signed [SW-1:0]  YMIN_S = SW'(YIELD_MIN);
  localparam logic signed [GSW-1:0] GMAX_S = GSW'(GRAD_MAX);
  localparam logic signed [GSW-1:0] GMIN_S = GSW'(GRAD_MIN);

  logic [ALPHA_W-1:0]      alpha_r;
  logic [COH_W-1:0]        coh_r;
  logic signed [W-1:0]     stress [N_ELEM];
  logic                    f_valid;
  logic [SQ_W-1:0]         f_sq [N_ELEM];
  logic [N_ELEM-1:0]       f_neg;
  logic [X9_W-1:0]         f_x9;
  logic signed [AT_W-1:0]  f_aterm;
  logic [R_W-1:0]          root;
  logic [G_W-1:0]          lane_q [N_ELEM];
  logic [N_ELEM-1:0]       lane_neg;
  logic signed [AT_W-1:0]  aterm_d [DEPTH];
  logic [DEPTH-1:0]        dev_d;
  logic [DEPTH-1:0]        vld_d;
  logic [GSW-1:0]          alpha_f;
  logic signed [SW-1:0]    ysum;
  logic signed [YIELD_W-1:0] yield_nxt;
  logic signed [GRAD_W-1:0]  grad_nxt [N_ELEM];
  logic                    out_valid_r;
  logic                    dev_out_r;
  logic signed [YIELD_W-1:0] yield_r;
  logic signed [GRAD_W-1:0]  grad_r [N_ELEM];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= '0;
      coh_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ALPHA: alpha_r <= cfg_data[ALPHA_W-1:0];
        CFG_COH:   coh_r   <= cfg_data[COH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign stress[0] = in_stress_xx;
  assign stress[1] = in_stress_xy;
  assign stress[2] = in_stress_xz;
  assign stress[3] = in_stress_yx;
  assign stress[4] = in_stress_yy;
  assign stress[5] = in_stress_yz;
  assign stress[6] = in_stress_zx;
  assign stress[7] = in_stress_zy;
  assign stress[8] = in_stress_zz;

  dpy_front #(.W(W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_s      (stress),
    .alpha     (alpha_r),
    .out_valid (f_valid),
    .sq        (f_sq),
    .neg       (f_neg),
    .x9        (f_x9),
    .aterm     (f_aterm)
  );

  dpy_root #(.W(W), .DEPTH(DEPTH)) u_root (
    .clk  (clk),
    .x9   (f_x9),
    .root (root)
  );

  for (genvar i = 0; i < N_ELEM; i++) begin : g_lane
    dpy_lane #(.W(W), .F(FRAC_BITS), .DEPTH(DEPTH)) u_lane (
      .clk   (clk),
      .sq    (f_sq[i]),
      .x9    (f_x9),
      .neg_i (f_neg[i]),
      .q     (lane_q[i]),
      .neg_o (lane_neg[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d <= '0;
    end else begin
      vld_d <= {vld_d[DEPTH-2:0], f_valid};
    end
  end

  always_ff @(posedge clk) begin
    aterm_d[0] <= f_aterm;
    dev_d      <= {dev_d[DEPTH-2:0], (f_x9 > THR)};
    for (int k = 1; k < DEPTH; k++) begin
      aterm_d[k] <= aterm_d[k-1];
    end
  end

  assign alpha_f = (GSW'(alpha_r) << SHL) >> SHR;

  always_comb begin
    logic signed [GSW-1:0] qv;
    logic signed [GSW-1:0] g;
    ysum = SW'(aterm_d[DEPTH-1]) + $signed(SW'(root)) - $signed(SW'(coh_r));
    if (ysum > YMAX_S) begin
      yield_nxt = YIELD_W'(YMAX_S);
    end else if (ysum < YMIN_S) begin
      yield_nxt = YIELD_W'(YMIN_S);
    end else begin
      yield_nxt = ysum[YIELD_W-1:0];
    end
    for (int i = 0; i < N_ELEM; i++) begin
      qv = $signed(GSW'(lane_q[i]));
      g  = dev_d[DEPTH-1] ? (lane_neg[i] ? -qv : qv) : '0;
      if (is_diag(i)) begin
        g = g + $signed(alpha_f);
      end
      if (g > GMAX_S) begin
        grad_nxt[i] = GRAD_W'(GMAX_S);
      end else if (g < GMIN_S) begin
        grad_nxt[i] = GRAD_W'(GMIN_S);
      end else begin
        grad_nxt[i] = g[GRAD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_d[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    yield_r   <= yield_nxt;
    grad_r    <= grad_nxt;
    dev_out_r <= dev_d[DEPTH-1];
  end

  assign out_valid       = out_valid_r;
  assign out_yield_value = yield_r;
  assign out_grad_xx     = grad_r[0];
  assign out_grad_xy     = grad_r[1];
  assign out_grad_xz     = grad_r[2];
  assign out_grad_yx     = grad_r[3];
  assign out_grad_yy     = grad_r[4];
  assign out_grad_yz     = grad_r[5];
  assign out_grad_zx     = grad_r[6];
  assign out_grad_zy     = grad_r[7];
  assign out_grad_zz     = grad_r[8];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("result strobe missing at the fixed latency");

  a_small_dev: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !dev_out_r) |->
      (out_grad_xy == '0) && (out_grad_yz == '0) && (out_grad_zx == '0))
    else $error("off-diagonal gradient nonzero for a small deviator");

  a_alpha_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index == CFG_ALPHA)) |=>
      (alpha_r == $past(cfg_data[ALPHA_W-1:0])))
    else $error("alpha register not updated by its write");

endmodule

### hdl/dpy_front.sv
// Front pipeline: trace, scaled deviator, squares, their sum and the pressure term.
module dpy_front #(
  parameter int W = dpy_pkg::STRESS_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [W-1:0]               in_s [dpy_pkg::N_ELEM],
  input  logic [dpy_pkg::ALPHA_W-1:0]       alpha,
  output logic                              out_valid,
  output logic [2*W+3:0]                    sq [dpy_pkg::N_ELEM],
  output logic [dpy_pkg::N_ELEM-1:0]        neg,
  output logic [2*W+7:0]                    x9,
  output logic signed [W+3:0]               aterm
);
  import dpy_pkg::*;

  localparam int NW   = W + 3;
  localparam int MW   = W + 2;
  localparam int SQ_W = 2 * MW;
  localparam int PS_W = SQ_W + 2;
  localparam int X9_W = SQ_W + 4;
  localparam int PR_W = W + 2 + ALPHA_W;
  localparam int AT_W = W + 4;

  logic [4:0]               vld_r;
  logic signed [W-1:0]      s_r [N_ELEM];
  logic signed [NW-1:0]     n_r [N_ELEM];
  logic signed [NW-1:0]     n_nxt [N_ELEM];
  logic signed [W+1:0]      i1_r;
  logic signed [W+1:0]      i1_nxt;
  logic [SQ_W-1:0]          sq3_r [N_ELEM];
  logic [SQ_W-1:0]          sq3_nxt [N_ELEM];
  logic [N_ELEM-1:0]        neg3_r;
  logic [N_ELEM-1:0]        neg3_nxt;
  logic [PR_W-1:0]          prod_r;
  logic [PR_W-1:0]          prod_nxt;
  logic                     ineg_r;
  logic [PS_W-1:0]          psum_r [3];
  logic [PS_W-1:0]          psum_nxt [3];
  logic [SQ_W-1:0]          sq4_r [N_ELEM];
  logic [N_ELEM-1:0]        neg4_r;
  logic signed [AT_W-1:0]   aterm4_r;
  logic signed [AT_W-1:0]   aterm4_nxt;
  logic [X9_W-1:0]          x9_r;
  logic [SQ_W-1:0]          sq5_r [N_ELEM];
  logic [N_ELEM-1:0]        neg5_r;
  logic signed [AT_W-1:0]   aterm5_r;

  always_comb begin
    logic signed [NW-1:0] tri_s;
    logic [W+1:0]         ai1;
    logic [PR_W-1:0]      tq;
    logic                 rnd;
    i1_nxt = (W+2)'(s_r[0]) + (W+2)'(s_r[4]) + (W+2)'(s_r[8]);
    for (int i = 0; i < N_ELEM; i++) begin
      tri_s = (NW'(s_r[i]) <<< 1) + NW'(s_r[i]);
      n_nxt[i] = is_diag(i) ? tri_s - NW'(i1_nxt) : tri_s;
    end
    for (int i = 0; i < N_ELEM; i++) begin
      neg3_nxt[i] = n_r[i][NW-1];
      sq3_nxt[i]  = SQ_W'(MW'(n_r[i][NW-1] ? -n_r[i] : n_r[i]))
                  * SQ_W'(MW'(n_r[i][NW-1] ? -n_r[i] : n_r[i]));
    end
    ai1      = i1_r[W+1] ? (W+2)'(-i1_r) : (W+2)'(i1_r);
    prod_nxt = PR_W'(ai1) * PR_W'(alpha);
    for (int g = 0; g < 3; g++) begin
      psum_nxt[g] = PS_W'(sq3_r[3*g]) + PS_W'(sq3_r[3*g+1]) + PS_W'(sq3_r[3*g+2]);
    end
    tq  = prod_r >> ALPHA_FRAC;
    rnd = ineg_r && (prod_r[ALPHA_FRAC-1:0] != '0);
    aterm4_nxt = ineg_r ? -(AT_W'(tq) + AT_W'(rnd)) : AT_W'(tq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    s_r      <= in_s;
    n_r      <= n_nxt;
    i1_r     <= i1_nxt;
    sq3_r    <= sq3_nxt;
    neg3_r   <= neg3_nxt;
    prod_r   <= prod_nxt;
    ineg_r   <= i1_r[W+1];
    psum_r   <= psum_nxt;
    sq4_r    <= sq3_r;
    neg4_r   <= neg3_r;
    aterm4_r <= aterm4_nxt;
    x9_r     <= X9_W'(psum_r[0]) + X9_W'(psum_r[1]) + X9_W'(psum_r[2]);
    sq5_r    <= sq4_r;
    neg5_r   <= neg4_r;
    aterm5_r <= aterm4_r;
  end

  assign out_valid = vld_r[4];
  assign sq        = sq5_r;
  assign neg       = neg5_r;
  assign x9        = x9_r;
  assign aterm     = aterm5_r;

endmodule

### hdl/dpy_root.sv
// Bit-per-stage square-root pipeline giving floor(sqrt(x9 / 18)).
module dpy_root #(
  parameter int W     = dpy_pkg::STRESS_WIDTH_DEF,
  parameter int DEPTH = W + 4
) (
  input  logic             clk,
  input  logic [2*W+7:0]   x9,
  output logic [W+3:0]     root
);
  import dpy_pkg::*;

  localparam int R_W = W + 4;
  localparam int SQW = 2 * R_W + 6;

  logic [SQW-1:0] rem_r [DEPTH];
  logic [R_W-1:0] r_r   [DEPTH];
  logic [SQW-1:0] rem_i [DEPTH];
  logic [R_W-1:0] r_i   [DEPTH];

  assign rem_i[0] = SQW'(x9);
  assign r_i[0]   = '0;

  for (genvar k = 1; k < DEPTH; k++) begin : g_link
    assign rem_i[k] = rem_r[k-1];
    assign r_i[k]   = r_r[k-1];
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    localparam int B = DEPTH - 1 - k;
    if (B < R_W) begin : g_step
      logic [SQW-1:0] y;
      logic [SQW-1:0] term;
      assign y    = (SQW'(r_i[k]) << (B + 1)) + (SQW'(1) << (2 * B));
      assign term = (y << 4) + (y << 1);
      always_ff @(posedge clk) begin
        if (term <= rem_i[k]) begin
          rem_r[k] <= rem_i[k] - term;
          r_r[k]   <= r_i[k] | (R_W'(1) << B);
        end else begin
          rem_r[k] <= rem_i[k];
          r_r[k]   <= r_i[k];
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        rem_r[k] <= rem_i[k];
        r_r[k]   <= r_i[k];
      end
    end
  end

  assign root = r_r[DEPTH-1];

endmodule

### hdl/dpy_lane.sv
// One gradient lane: bit-per-stage quotient |N| * 2^F / sqrt(2 * x9), truncated.
module dpy_lane #(
  parameter int W     = dpy_pkg::STRESS_WIDTH_DEF,
  parameter int F     = dpy_pkg::FRAC_BITS_DEF,
  parameter int DEPTH = F + 2
) (
  input  logic             clk,
  input  logic [2*W+3:0]   sq,
  input  logic [2*W+7:0]   x9,
  input  logic             neg_i,
  output logic [F+1:0]     q,
  output logic             neg_o
);
  import dpy_pkg::*;

  localparam int G_W = F + 2;
  localparam int XW  = 2 * W + 8;
  localparam int RW2 = 2 * W + 4 + 2 * F;
  localparam int LW0 = XW + 2 * G_W + 3;
  localparam int LW  = (RW2 > LW0) ? RW2 : LW0;

  logic [LW-1:0]  rem_r [DEPTH];
  logic [LW-1:0]  t_r   [DEPTH];
  logic [G_W-1:0] q_r   [DEPTH];
  logic [XW:0]    tx_r  [DEPTH];
  logic           neg_r [DEPTH];
  logic [LW-1:0]  rem_i [DEPTH];
  logic [LW-1:0]  t_i   [DEPTH];
  logic [G_W-1:0] q_i   [DEPTH];
  logic [XW:0]    tx_i  [DEPTH];
  logic           neg_w [DEPTH];

  assign rem_i[0] = LW'(sq) << (2 * F);
  assign t_i[0]   = '0;
  assign q_i[0]   = '0;
  assign tx_i[0]  = {x9, 1'b0};
  assign neg_w[0] = neg_i;

  for (genvar k = 1; k < DEPTH; k++) begin : g_link
    assign rem_i[k] = rem_r[k-1];
    assign t_i[k]   = t_r[k-1];
    assign q_i[k]   = q_r[k-1];
    assign tx_i[k]  = tx_r[k-1];
    assign neg_w[k] = neg_r[k-1];
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    localparam int B = DEPTH - 1 - k;
    if (B < G_W) begin : g_step
      logic [LW-1:0] term;
      assign term = (t_i[k] << (B + 1)) + (LW'(tx_i[k]) << (2 * B));
      always_ff @(posedge clk) begin
        tx_r[k]  <= tx_i[k];
        neg_r[k] <= neg_w[k];
        if (term <= rem_i[k]) begin
          rem_r[k] <= rem_i[k] - term;
          q_r[k]   <= q_i[k] | (G_W'(1) << B);
          t_r[k]   <= t_i[k] + (LW'(tx_i[k]) << B);
        end else begin
          rem_r[k] <= rem_i[k];
          q_r[k]   <= q_i[k];
          t_r[k]   <= t_i[k];
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        tx_r[k]  <= tx_i[k];
        neg_r[k] <= neg_w[k];
        rem_r[k] <= rem_i[k];
        q_r[k]   <= q_i[k];
        t_r[k]   <= t_i[k];
      end
    end
  end

  assign q     = q_r[DEPTH-1];
  assign neg_o = neg_r[DEPTH-1];

endmodule

### test/testbench.sv
// Self-checking testbench for the Drucker-Prager yield evaluator with its own predictor.
`timescale 1ns / 1ps

module testbench;
  import dpy_pkg::*;

  typedef logic signed [31:0] stress_t;
  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic [8:0][31:0] tensor_t;

  typedef struct packed {
    logic [YIELD_W-1:0]       yv;
    logic [8:0][GRAD_W-1:0]   g;
  } yield_res_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  tensor_t drv;
  logic out_valid;
  logic signed [YIELD_W-1:0] out_yield_value;
  grad_t out_g [9];
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tensor_t stress_q[$];
  yield_res_t result_q[$];
  logic [ALPHA_W-1:0] alpha_reg;
  logic [COH_W-1:0] coh_reg;
  int idle_pct;
  int errors;

  drucker_prager_yield_eval i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_stress_xx(drv[0]), .in_stress_xy(drv[1]), .in_stress_xz(drv[2]),
    .in_stress_yx(drv[3]), .in_stress_yy(drv[4]), .in_stress_yz(drv[5]),
    .in_stress_zx(drv[6]), .in_stress_zy(drv[7]), .in_stress_zz(drv[8]),
    .out_valid(out_valid), .out_yield_value(out_yield_value),
    .out_grad_xx(out_g[0]), .out_grad_xy(out_g[1]), .out_grad_xz(out_g[2]),
    .out_grad_yx(out_g[3]), .out_grad_yy(out_g[4]), .out_grad_yz(out_g[5]),
    .out_grad_zx(out_g[6]), .out_grad_zy(out_g[7]), .out_grad_zz(out_g[8]),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic yield_res_t yield_and_gradient(input tensor_t t);
    yield_res_t res;
    longint s [9];
    longint n [9];
    longint i1;
    longint aterm;
    longint yv;
    longint g;
    logic [127:0] x9;
    logic [127:0] an;
    logic [127:0] c;
    logic [127:0] r;
    logic [127:0] q;
    logic [127:0] rhs;
    logic [127:0] thr;
    logic dev_on;
    for (int i = 0; i < 9; i++) s[i] = longint'(stress_t'(t[i]));
    i1 = s[0] + s[4] + s[8];
    x9 = '0;
    for (int i = 0; i < 9; i++) begin
      n[i] = (i == 0 || i == 4 || i == 8) ? 3 * s[i] - i1 : 3 * s[i];
      an = n[i] < 0 ? -n[i] : n[i];
      x9 = x9 + an * an;
    end
    aterm = (i1 * longint'(alpha_reg)) >>> ALPHA_FRAC;
    r = '0;
    for (int b = 55; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c * 18 <= x9) r = c;
    end
    yv = aterm + longint'(r) - longint'(coh_reg);
    res.yv = YIELD_W'(sat(yv, YIELD_MIN, YIELD_MAX));
    thr = (128'd9 << 32) / 1000000;
    dev_on = x9 > thr;
    for (int i = 0; i < 9; i++) begin
      g = 0;
      if (dev_on && n[i] != 0) begin
        an = n[i] < 0 ? -n[i] : n[i];
        rhs = (an * an) << 32;
        q = '0;
        for (int b = 17; b >= 0; b--) begin
          c = q | (128'd1 << b);
          if ((x9 << 1) * c * c <= rhs) q = c;
        end
        g = n[i] < 0 ? -longint'(q) : longint'(q);
      end
      if (i == 0 || i == 4 || i == 8) g += longint'(alpha_reg);
      res.g[i] = GRAD_W'(sat(g, GRAD_MIN, GRAD_MAX));
    end
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (start && !busy) result_q.push_back(yield_and_gradient(drv));
    if ((start && !busy) || !start) begin
      if (rst_n && stress_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        drv <= stress_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    yield_res_t exp_r;
    if (out_valid) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result, yield %0d", $time, out_yield_value);
        errors++;
      end else begin
        exp_r = result_q.pop_front();
        if (exp_r.yv !== out_yield_value) begin
          $display("%0t: yield_value expected %0d actual %0d", $time,
                   $signed(exp_r.yv), out_yield_value);
          errors++;
        end
        for (int i = 0; i < 9; i++) begin
          if (exp_r.g[i] !== out_g[i]) begin
            $display("%0t: grad[%0d] expected %0d actual %0d", $time, i,
                     $signed(exp_r.g[i]), out_g[i]);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ALPHA) alpha_reg = value[ALPHA_W-1:0];
    else coh_reg = value[COH_W-1:0];
  endtask

  task automatic drain();
    while (stress_q.size() != 0 || start || result_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic tensor_t random_tensor();
    tensor_t t;
    int kind;
    stress_t base;
    kind = $urandom_range(5);
    base = $urandom;
    for (int i = 0; i < 9; i++) begin
      case (kind)
        0: t[i] = $urandom;
        1: t[i] = $signed($urandom_range(131072)) - 65536;
        2: t[i] = (i == 0 || i == 4 || i == 8) ? base + $urandom_range(40) : $urandom_range(3);
        3: t[i] = $signed($urandom_range(2000)) - 1000;
        4: t[i] = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        default: t[i] = $signed($urandom) >>> $urandom_range(31);
      endcase
    end
    return t;
  endfunction

  task automatic directed_items();
    tensor_t t;
    stress_q.push_back('0);
    stress_q.push_back({9{32'h7fffffff}});
    stress_q.push_back({9{32'h80000000}});
    stress_q.push_back({9{32'hffffffff}});
    stress_q.push_back({9{32'h00000001}});
    t = '0; t[0] = 32'h7fffffff; stress_q.push_back(t);
    t = '0; t[0] = 32'h7fffffff; t[4] = 32'h80000000; stress_q.push_back(t);
    t = '0; t[1] = 32'h80000000; stress_q.push_back(t);
    t = '0; t[0] = 32'd1; stress_q.push_back(t);
    t = '0; t[0] = 32'd60; stress_q.push_back(t);
    t = '0; t[0] = 32'd62; stress_q.push_back(t);
    t = '0; t[2] = 32'd37; stress_q.push_back(t);
    t = '0; t[2] = 32'd38; stress_q.push_back(t);
    t = {9{32'h80000000}}; t[4] = 32'h7fffffff; stress_q.push_back(t);
    t = {32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
         32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000};
    stress_q.push_back(t);
    t = {32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
         32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555};
    stress_q.push_back(t);
    t = '0; t[0] = 32'h00010000; t[4] = 32'h00010000; t[8] = 32'h00010000;
    stress_q.push_back(t);
    t = '0; t[8] = 32'hffff0000; stress_q.push_back(t);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    drv = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ALPHA;
    cfg_data = '0;
    alpha_reg = '0;
    coh_reg = '0;
    idle_pct = 22;
    errors = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    directed_items();
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(CFG_ALPHA, 32'hffffffff); write_reg(CFG_COH, 32'hffffffff); end
        1: begin write_reg(CFG_ALPHA, 32'h0); write_reg(CFG_COH, 32'h0); end
        2: begin write_reg(CFG_ALPHA, 32'h1ffff); write_reg(CFG_COH, 32'h0); end
        3: begin write_reg(CFG_ALPHA, 32'h0); write_reg(CFG_COH, 32'h7fffffff); end
        default: begin write_reg(CFG_ALPHA, $urandom); write_reg(CFG_COH, $urandom); end
      endcase
      idle_pct = (phase == 2) ? 0 : 22;
      if (phase < 2) directed_items();
      for (int k = 0; k < 180; k++) stress_q.push_back(random_tensor());
      drain();
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### drucker_prager_yield_eval.f
hdl/dpy_pkg.sv
hdl/dpy_front.sv
hdl/dpy_root.sv
hdl/dpy_lane.sv
hdl/drucker_prager_yield_eval.sv
test/testbench.sv
